// ===== design/rrmt_pkg.sv =====
// package for the round-robin miss table: item types, codes and sequencer states
`default_nettype none

package rrmt_pkg;

    typedef enum logic [1:0] {
        ACT_POST   = 2'd0,
        ACT_ISSUE  = 2'd1,
        ACT_RESP   = 2'd2,
        ACT_CANCEL = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_WAKE  = 2'd1,
        KIND_FREED = 2'd2,
        KIND_MISS  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CS_IDLE  = 2'd0,
        CS_REQ   = 2'd1,
        CS_WAIT  = 2'd2,
        CS_WOKEN = 2'd3
    } t_ctx_st;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PORT,
        ST_CSCAN,
        ST_ESCAN,
        ST_ISSUE,
        ST_TRD,
        ST_TCMP,
        ST_RESP,
        ST_CLOSE
    } t_state;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  context_req;
        logic [63:0] line_address;
        logic [1:0]  port_full;
        logic [31:0] resp_tag;
        logic        resp_has_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        port;
        logic [2:0]  ctx_out;
        logic [63:0] addr_out;
        logic [31:0] tag_out;
        logic        data_present;
        logic        last;
    } t_out_item;

    // sequencer to result queue
    typedef struct packed {
        logic      push;
        logic      close;
        t_out_item item;
    } t_oq_ctl;

    // result queue back to sequencer
    typedef struct packed {
        logic can_push;
        logic pend_valid;
    } t_oq_sts;

endpackage

`default_nettype wire

// ===== design/rrmt_outq.sv =====
// result queue: holds one result back until the next one or the item end sets its last flag
`default_nettype none

module rrmt_outq
    import rrmt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_oq_ctl   i_ctl,
    output t_oq_sts        o_sts,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    logic      r_out_v;
    t_out_item r_out;
    logic      r_pend_v;
    t_out_item r_pend;

    logic      out_free;
    logic      can_push;
    logic      do_push;
    logic      do_close;
    t_out_item pend_fin;

    assign out_free = !r_out_v || i_out_ready;
    assign can_push = !r_pend_v || out_free;
    assign do_push  = i_ctl.push && can_push;
    assign do_close = i_ctl.close && can_push && r_pend_v;

    always_comb begin
        pend_fin      = r_pend;
        pend_fin.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_pend_v <= 1'b0;
        end else begin
            if ((do_push && r_pend_v) || do_close) begin
                r_out_v <= 1'b1;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (do_push) begin
                r_pend_v <= 1'b1;
            end else if (do_close) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            if (r_pend_v) begin
                r_out <= r_pend;
            end
            r_pend <= i_ctl.item;
        end else if (do_close) begin
            r_out <= pend_fin;
        end
    end

    assign o_sts.can_push   = can_push;
    assign o_sts.pend_valid = r_pend_v;
    assign o_out_valid      = r_out_v;
    assign o_out_item       = r_out;

endmodule

`default_nettype wire

// ===== design/round_robin_miss_table_issue.sv =====
// top level: context request table, miss table and the scan sequencer
`default_nettype none

// Miss table with round-robin issue. Posts and cancels are taken in the idle
// state. An issue tick handles the memory ports in order; for each port that is
// not full one scan counter walks the contexts from the round-robin pointer (one
// context a cycle, up to NUM_CTX) and then the miss table for the lowest free
// entry (one entry a cycle, up to NUM_CTX), stopping when no context requests or
// the table is full. A response walks the table for its tag (registered read of
// the table memory, then a compare), up to NUM_CTX entries. The input is ready
// again once the last result of an item sits in the output register.
module round_robin_miss_table_issue
    import rrmt_pkg::*;
#(
    parameter int NUM_CTX   = 8,
    parameter int NUM_PORTS = 2
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    localparam int CIW = (NUM_CTX > 1) ? $clog2(NUM_CTX) : 1;
    localparam int PW  = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
    localparam logic [CIW-1:0] CTX_LAST  = CIW'(NUM_CTX - 1);
    localparam logic [PW-1:0]  PORT_LAST = PW'(NUM_PORTS - 1);

    function automatic logic [CIW-1:0] inc_wrap(input logic [CIW-1:0] v);
        logic [CIW-1:0] r;
        r = (v == CTX_LAST) ? '0 : v + 1'b1;
        return r;
    endfunction

    t_state   r_state;
    t_state   n_state;

    // context table and miss table valid bits
    t_ctx_st        r_ctx_state [NUM_CTX];
    logic [NUM_CTX-1:0] r_ent_v;
    logic [CIW-1:0] r_rr;
    logic [31:0]    r_tag_ctr;

    // memories
    logic [63:0]    ctx_line   [NUM_CTX];
    logic [63:0]    ent_addr   [NUM_CTX];
    logic [CIW-1:0] ent_waiter [NUM_CTX];
    logic [31:0]    ent_tag    [NUM_CTX];
    logic [63:0]    r_line_rd;
    logic [63:0]    r_ent_addr_rd;
    logic [CIW-1:0] r_ent_waiter_rd;
    logic [31:0]    r_ent_tag_rd;

    // per-item working registers
    logic [1:0]     r_full;
    logic [31:0]    r_rtag;
    logic           r_has_data;
    logic [PW-1:0]  r_port;
    logic [CIW-1:0] r_idx;
    logic [CIW-1:0] r_cnt;
    logic [CIW-1:0] r_leader;
    logic           r_hit;

    t_oq_ctl oq_ctl;
    t_oq_sts oq_sts;

    logic           in_fire;
    t_action        in_act;
    logic           cx_in_rng;
    logic [CIW-1:0] cx_idx;
    logic           port_blk;
    logic           port_last;
    logic           cnt_last;
    logic           is_req;
    logic           ent_free;
    logic           tag_match;
    logic           wake;

    assign in_fire   = i_in_valid && o_in_ready;
    assign in_act    = t_action'(i_in_item.action);
    assign cx_in_rng = int'(i_in_item.context_req) < NUM_CTX;
    assign cx_idx    = CIW'(i_in_item.context_req);
    // only the first two ports have a full bit
    assign port_blk  = (int'(r_port) < 2) && r_full[r_port[0]];
    assign port_last = (r_port == PORT_LAST);
    assign cnt_last  = (r_cnt == CTX_LAST);
    assign is_req    = (r_ctx_state[r_idx] == CS_REQ);
    assign ent_free  = !r_ent_v[r_idx];
    assign tag_match = r_ent_v[r_idx] && (r_ent_tag_rd == r_rtag);
    assign wake      = (r_ctx_state[r_ent_waiter_rd] == CS_WAIT);

    rrmt_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (oq_ctl),
        .o_sts       (oq_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (in_act == ACT_ISSUE) begin
                        n_state = ST_PORT;
                    end else if (in_act == ACT_RESP) begin
                        n_state = ST_TRD;
                    end
                end
            end
            ST_PORT: begin
                if (!port_blk) begin
                    n_state = ST_CSCAN;
                end else if (port_last) begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CSCAN: begin
                if (is_req) begin
                    n_state = ST_ESCAN;
                end else if (cnt_last) begin
                    n_state = ST_CLOSE;
                end
            end
            ST_ESCAN: begin
                if (ent_free || cnt_last) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (oq_sts.can_push) begin
                    n_state = (!r_hit || port_last) ? ST_CLOSE : ST_PORT;
                end
            end
            ST_TRD: n_state = ST_TCMP;
            ST_TCMP: begin
                n_state = (tag_match || cnt_last) ? ST_RESP : ST_TRD;
            end
            ST_RESP: begin
                if (oq_sts.can_push) begin
                    n_state = ST_CLOSE;
                end
            end
            ST_CLOSE: begin
                if (oq_sts.can_push) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready = 1'b0;
        oq_ctl     = '0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_ISSUE: begin
                oq_ctl.push      = oq_sts.can_push;
                oq_ctl.item.port = r_port[0];
                if (r_hit) begin
                    oq_ctl.item.kind     = KIND_LOAD;
                    oq_ctl.item.ctx_out  = 3'(r_leader);
                    oq_ctl.item.addr_out = r_line_rd;
                    oq_ctl.item.tag_out  = r_tag_ctr;
                end else begin
                    oq_ctl.item.kind = KIND_MISS;
                end
            end
            ST_RESP: begin
                oq_ctl.push         = oq_sts.can_push;
                oq_ctl.item.tag_out = r_rtag;
                if (!r_hit) begin
                    oq_ctl.item.kind = KIND_MISS;
                end else begin
                    oq_ctl.item.kind         = wake ? KIND_WAKE : KIND_FREED;
                    oq_ctl.item.ctx_out      = 3'(r_ent_waiter_rd);
                    oq_ctl.item.addr_out     = r_ent_addr_rd;
                    oq_ctl.item.data_present = wake && r_has_data;
                end
            end
            ST_CLOSE: oq_ctl.close = oq_sts.can_push;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            for (int i = 0; i < NUM_CTX; i++) begin
                r_ctx_state[i] <= CS_IDLE;
            end
            r_ent_v   <= '0;
            r_rr      <= '0;
            r_tag_ctr <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire && cx_in_rng) begin
                        if (in_act == ACT_POST) begin
                            r_ctx_state[cx_idx] <= CS_REQ;
                        end else if (in_act == ACT_CANCEL) begin
                            r_ctx_state[cx_idx] <= CS_IDLE;
                        end
                    end
                end
                ST_CSCAN: begin
                    if (is_req) begin
                        r_rr <= inc_wrap(r_idx);
                    end
                end
                ST_ISSUE: begin
                    if (oq_ctl.push && r_hit) begin
                        r_ent_v[r_idx]        <= 1'b1;
                        r_tag_ctr             <= r_tag_ctr + 32'd1;
                        r_ctx_state[r_leader] <= CS_WAIT;
                    end
                end
                ST_RESP: begin
                    if (oq_ctl.push && r_hit) begin
                        r_ent_v[r_idx] <= 1'b0;
                        if (wake) begin
                            r_ctx_state[r_ent_waiter_rd] <= CS_WOKEN;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // scan counter and per-item registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_full     <= i_in_item.port_full;
                    r_rtag     <= i_in_item.resp_tag;
                    r_has_data <= i_in_item.resp_has_data;
                    r_port     <= '0;
                    r_idx      <= '0;
                    r_cnt      <= '0;
                end
            end
            ST_PORT: begin
                if (!port_blk) begin
                    r_idx <= r_rr;
                    r_cnt <= '0;
                end else if (!port_last) begin
                    r_port <= r_port + 1'b1;
                end
            end
            ST_CSCAN: begin
                if (is_req) begin
                    r_leader <= r_idx;
                    r_idx    <= '0;
                    r_cnt    <= '0;
                end else begin
                    r_idx <= inc_wrap(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_ESCAN: begin
                if (ent_free) begin
                    r_hit <= 1'b1;
                end else if (cnt_last) begin
                    r_hit <= 1'b0;
                end else begin
                    r_idx <= inc_wrap(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_ISSUE: begin
                if (oq_ctl.push && r_hit && !port_last) begin
                    r_port <= r_port + 1'b1;
                end
            end
            ST_TCMP: begin
                if (tag_match) begin
                    r_hit <= 1'b1;
                end else if (cnt_last) begin
                    r_hit <= 1'b0;
                end else begin
                    r_idx <= inc_wrap(r_idx);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // context line memory: written by a post, read for the chosen context
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_fire && in_act == ACT_POST && cx_in_rng) begin
            ctx_line[cx_idx] <= i_in_item.line_address;
        end
        if (r_state == ST_CSCAN) begin
            r_line_rd <= ctx_line[r_idx];
        end
    end

    // miss table memory: written at issue, read during the tag search
    always_ff @(posedge i_clk) begin
        if (r_state == ST_ISSUE && oq_ctl.push && r_hit) begin
            ent_addr[r_idx]   <= r_line_rd;
            ent_waiter[r_idx] <= r_leader;
            ent_tag[r_idx]    <= r_tag_ctr;
        end
        if (r_state == ST_TRD) begin
            r_ent_addr_rd   <= ent_addr[r_idx];
            r_ent_waiter_rd <= ent_waiter[r_idx];
            r_ent_tag_rd    <= ent_tag[r_idx];
        end
    end

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !oq_sts.pend_valid)
        else $error("pending result left over at item end");

    a_tag_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE && oq_ctl.push && r_hit)
            |=> r_tag_ctr == $past(r_tag_ctr) + 32'd1)
        else $error("tag counter did not advance on issue");

    a_rr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rr <= CTX_LAST)
        else $error("round-robin pointer out of range");

    a_load_from_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (oq_ctl.push && r_state == ST_ISSUE && r_hit) |-> r_ctx_state[r_leader] == CS_REQ)
        else $error("load issued for a context that is not requesting");

    a_free_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (oq_ctl.push && r_state == ST_ISSUE && r_hit) |-> !r_ent_v[r_idx])
        else $error("load allocated into a busy entry");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_round_robin_miss_table_issue.sv =====
// testbench for the round-robin miss table: directed and random transfers checked against a predictor
module tb_round_robin_miss_table_issue;
    import rrmt_pkg::*;

    localparam int NUM_CTX        = 8;
    localparam int NUM_PORTS      = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int RAND_ITEMS     = 1626;
    localparam int CALM_ITEMS     = 200;
    localparam int HOLD_AT        = 400;
    localparam int PAUSE_AT       = 1000;
    localparam int HOLD_CYCLES    = 300;
    localparam int BURST_ITEMS    = 16;
    localparam int TAIL_CYCLES    = 60;
    localparam int WATCHDOG_LIMIT = 4000;

    class miss_table_scoreboard;
        t_ctx_st     ctx_st[NUM_CTX];
        logic [63:0] ctx_line[NUM_CTX];
        bit          ent_valid[NUM_CTX];
        logic [63:0] ent_addr[NUM_CTX];
        logic [2:0]  ent_waiter[NUM_CTX];
        logic [31:0] ent_tag[NUM_CTX];
        logic [31:0] next_tag;
        int          rr_ptr;
        t_out_item   expected_results[$];
        int errors, n_checked, n_load, n_wake, n_freed, n_unknown, n_stall;

        function new();
            for (int i = 0; i < NUM_CTX; i++) begin
                ctx_st[i]    = CS_IDLE;
                ent_valid[i] = 1'b0;
            end
            next_tag  = '0;
            rr_ptr    = 0;
            errors    = 0;
            n_checked = 0;
            n_load    = 0;
            n_wake    = 0;
            n_freed   = 0;
            n_unknown = 0;
            n_stall   = 0;
        endfunction

        function bit busy();
            return expected_results.size() != 0;
        endfunction

        // tag of a random outstanding load, or one that cannot match
        function logic [31:0] live_tag();
            int picks[$];
            for (int i = 0; i < NUM_CTX; i++) begin
                if (ent_valid[i]) picks.push_back(i);
            end
            if (picks.size() == 0) return {1'b1, 31'($urandom)};
            return ent_tag[picks[$urandom_range(0, picks.size() - 1)]];
        endfunction

        function void note_input(t_in_item it);
            t_out_item res[NUM_PORTS];
            t_out_item r;
            int n, leader, slot, idx;
            n = 0;
            case (it.action)
                ACT_POST: begin
                    ctx_st[it.context_req]   = CS_REQ;
                    ctx_line[it.context_req] = it.line_address;
                end
                ACT_CANCEL: begin
                    ctx_st[it.context_req] = CS_IDLE;
                end
                ACT_ISSUE: begin
                    for (int p = 0; p < NUM_PORTS; p++) begin
                        if (it.port_full[p]) continue;
                        leader = -1;
                        for (int i = 0; i < NUM_CTX; i++) begin
                            idx = (rr_ptr + i) % NUM_CTX;
                            if (ctx_st[idx] == CS_REQ) begin
                                leader = idx;
                                break;
                            end
                        end
                        if (leader < 0) break;
                        // pointer moves past the leader even when the table is full
                        rr_ptr = (leader + 1) % NUM_CTX;
                        slot = -1;
                        for (int i = 0; i < NUM_CTX; i++) begin
                            if (!ent_valid[i]) begin
                                slot = i;
                                break;
                            end
                        end
                        r = '0;
                        r.port = 1'(p);
                        if (slot < 0) begin
                            r.kind = KIND_MISS;
                            res[n] = r;
                            n++;
                            n_stall++;
                            break;
                        end
                        ent_valid[slot]  = 1'b1;
                        ent_addr[slot]   = ctx_line[leader];
                        ent_waiter[slot] = 3'(leader);
                        ent_tag[slot]    = next_tag;
                        r.kind     = KIND_LOAD;
                        r.ctx_out  = 3'(leader);
                        r.addr_out = ctx_line[leader];
                        r.tag_out  = next_tag;
                        res[n] = r;
                        n++;
                        next_tag = next_tag + 32'd1;
                        ctx_st[leader] = CS_WAIT;
                        n_load++;
                    end
                end
                default: begin
                    slot = -1;
                    for (int i = 0; i < NUM_CTX; i++) begin
                        if (ent_valid[i] && ent_tag[i] == it.resp_tag) begin
                            slot = i;
                            break;
                        end
                    end
                    r = '0;
                    r.tag_out = it.resp_tag;
                    if (slot < 0) begin
                        r.kind = KIND_MISS;
                        n_unknown++;
                    end else begin
                        idx = ent_waiter[slot];
                        r.ctx_out  = ent_waiter[slot];
                        r.addr_out = ent_addr[slot];
                        if (ctx_st[idx] == CS_WAIT) begin
                            ctx_st[idx] = CS_WOKEN;
                            r.kind = KIND_WAKE;
                            r.data_present = it.resp_has_data;
                            n_wake++;
                        end else begin
                            // waiter was cancelled or reposted
                            r.kind = KIND_FREED;
                            n_freed++;
                        end
                        ent_valid[slot] = 1'b0;
                    end
                    res[n] = r;
                    n++;
                end
            endcase
            if (n > 0) res[n - 1].last = 1'b1;
            for (int k = 0; k < n; k++) expected_results.push_back(res[k]);
        endfunction

        function void field_diff(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            n_checked++;
            field_diff("kind", 64'(want.kind), 64'(got.kind));
            field_diff("port", 64'(want.port), 64'(got.port));
            field_diff("ctx_out", 64'(want.ctx_out), 64'(got.ctx_out));
            field_diff("addr_out", want.addr_out, got.addr_out);
            field_diff("tag_out", 64'(want.tag_out), 64'(got.tag_out));
            field_diff("data_present", 64'(want.data_present), 64'(got.data_present));
            field_diff("last", 64'(want.last), 64'(got.last));
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    miss_table_scoreboard sb;
    bit calm;
    bit want_hold;
    bit hold_on;
    int n_items;
    int quiet_cycles;

    round_robin_miss_table_issue #(
        .NUM_CTX   (NUM_CTX),
        .NUM_PORTS (NUM_PORTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic t_in_item mk_item(t_action act, int ctx, logic [63:0] addr,
                                         logic [1:0] full, logic [31:0] tag, bit data);
        t_in_item it;
        it.action        = act;
        it.context_req   = 3'(ctx);
        it.line_address  = addr;
        it.port_full     = full;
        it.resp_tag      = tag;
        it.resp_has_data = data;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_input(it);
        n_items++;
    endtask

    task automatic offer(input t_in_item it);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        send_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (sb.busy());
    endtask

    // result side: random stall bursts, one long hold-off on request
    initial begin : out_ready_drive
        forever begin
            if (want_hold && !hold_on) begin
                hold_on   = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on = 1'b0;
            end else if (!calm && $urandom_range(0, 1)) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_item);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item it;
        int sel;
        sb = new();
        calm = 1'b0;
        want_hold = 1'b0;
        n_items = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // nothing requesting, then an unknown tag
        offer(mk_item(ACT_ISSUE, 0, 64'h0, 2'b00, 32'h0, 1'b0));
        offer(mk_item(ACT_RESP, 0, 64'h0, 2'b00, 32'hffff_ffff, 1'b1));
        offer(mk_item(ACT_POST, 0, 64'hffff_ffff_ffff_ffff, 2'b11, 32'h0, 1'b0));
        offer(mk_item(ACT_POST, 7, 64'h0, 2'b00, 32'hffff_ffff, 1'b1));
        // both ports full, then each port alone
        offer(mk_item(ACT_ISSUE, 0, 64'h0, 2'b11, 32'h0, 1'b0));
        offer(mk_item(ACT_ISSUE, 0, 64'h0, 2'b01, 32'h0, 1'b0));
        offer(mk_item(ACT_ISSUE, 0, 64'h0, 2'b10, 32'h0, 1'b0));
        offer(mk_item(ACT_RESP, 0, 64'h0, 2'b00, 32'h0, 1'b1));
        // cancelled waiter: entry freed without a wake
        offer(mk_item(ACT_CANCEL, 7, 64'h0, 2'b00, 32'h0, 1'b0));
        offer(mk_item(ACT_RESP, 0, 64'h0, 2'b00, 32'h1, 1'b1));
        // fill the table, then one more request stalls
        for (int c = 0; c < NUM_CTX; c++) begin
            offer(mk_item(ACT_POST, c, {$urandom, $urandom}, 2'b00, 32'h0, 1'b0));
        end
        repeat (4) offer(mk_item(ACT_ISSUE, 0, 64'h0, 2'b00, 32'h0, 1'b0));
        offer(mk_item(ACT_POST, 3, 64'h8000_0000_0000_0001, 2'b00, 32'h0, 1'b0));
        offer(mk_item(ACT_ISSUE, 0, 64'h0, 2'b00, 32'h0, 1'b0));
        drain();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
            if (n == PAUSE_AT) drain();
            if (n == HOLD_AT) begin
                // receiver holds off while a burst of responses backs up the block
                i_in_valid <= 1'b0;
                want_hold = 1'b1;
                do begin
                    @(posedge i_clk);
                end while (!hold_on);
                want_hold = 1'b0;
                for (int b = 0; b < BURST_ITEMS; b++) begin
                    send_item(mk_item(ACT_RESP, 0, 64'h0, 2'b00, {1'b1, 31'($urandom)},
                                      1'($urandom)));
                end
            end
            it.context_req   = 3'($urandom);
            it.line_address  = {$urandom, $urandom};
            it.port_full     = 2'($urandom);
            it.resp_tag      = $urandom;
            it.resp_has_data = 1'($urandom);
            sel = $urandom_range(0, 99);
            if (sel < 34) begin
                it.action = ACT_POST;
            end else if (sel < 64) begin
                it.action = ACT_ISSUE;
                if ($urandom_range(0, 9) < 7) it.port_full = 2'b00;
            end else if (sel < 88) begin
                it.action = ACT_RESP;
                it.resp_tag = sb.live_tag();
            end else if (sel < 94) begin
                it.action = ACT_CANCEL;
            end else begin
                it.action = ACT_RESP;
            end
            offer(it);
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d transfers in, %0d results: %0d loads, %0d wakes, %0d freed",
                 n_items, sb.n_checked, sb.n_load, sb.n_wake, sb.n_freed);
        $display("unknown tags %0d, table-full stalls %0d, mismatches %0d",
                 sb.n_unknown, sb.n_stall, sb.errors);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/rrmt_pkg.sv
design/rrmt_outq.sv
design/round_robin_miss_table_issue.sv
bench/tb_round_robin_miss_table_issue.sv
